// ===== src/psis_pkg.sv =====
// Package for the per-stream interval statistics unit.
// Holds the table entry type, status and command codes, and field widths.
// No dependencies.
`default_nettype none
package psis_pkg;

  localparam int GAP_BITS = 40;
  localparam logic [GAP_BITS-1:0] GAP_MAX = '1;

  typedef enum logic [1:0] {
    CMD_RECORD = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_NEW        = 3'd0,
    ST_EXISTING   = 3'd1,
    ST_FULL       = 3'd2,
    ST_READ_VALID = 3'd3,
    ST_READ_EMPTY = 3'd4,
    ST_CLEARED    = 3'd5
  } status_t;

  // one table entry; first member in the top bits
  typedef struct packed {
    logic [31:0]         etype;
    logic [31:0]         sender;
    logic [63:0]         last;
    logic [31:0]         count;
    logic [GAP_BITS-1:0] min_gap;
    logic [GAP_BITS-1:0] max_gap;
    logic [55:0]         sum;
    logic [63:0]         sq;
    logic [31:0]         late;
  } entry_t;

  // register map: byte address bit 3 selects the register
  localparam logic REG_GROUP   = 1'b0;
  localparam logic REG_MIN_GAP = 1'b1;

  localparam logic [39:0] MIN_GAP_RESET = 40'd60000000000;

  function automatic logic [31:0] inc_sat32(input logic [31:0] v);
    inc_sat32 = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage
`default_nettype wire

// ===== src/per_stream_interval_statistics_unit.sv =====
// Per-stream interval statistics: keyed table of gap statistics per stream.
// Record: accept, then a key search over the table (one memory read per slot); a key hit
// goes on through gap, square and write-back; then output.
// A read of a valid slot waits for the registered memory read, other commands go straight
// to output. One item at a time; throughput is set by the slot-by-slot key search.
// Reset (rst_n, synchronous): table empty, global counters zero, registers at defaults.
`default_nettype none
module per_stream_interval_statistics_unit #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input: type_id, sender_id, sample_time_us, read_slot (from bit 0)
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [135:0] in_tdata,
  input  wire logic [1:0]   in_tuser,   // command
  // output: slot, out_type, out_sender, sample_count, min_gap_us, max_gap_us,
  // gap_sum_us, gap_sq_sum, stream_late_count, late_count (from bit 0)
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [367:0]      out_tdata,
  output logic [2:0]        out_tuser,  // status
  // configuration
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [3:0]   cfg_paddr,
  input  wire logic [63:0]  cfg_pwdata,
  output logic [63:0]       cfg_prdata,
  output logic              cfg_pready
);
  import psis_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SEARCH, S_RDWAIT, S_GAP, S_SQ, S_WRITE, S_OUT
  } state_t;

  state_t state_r;

  // configuration registers
  logic        grp_r;
  logic [39:0] min_start_r;

  // captured item
  logic [31:0] type_r, sender_r;
  logic [63:0] time_r;

  // global ordering
  logic [63:0] glast_r;
  logic        gseen_r;
  logic [31:0] glate_r;

  // table
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [IW-1:0] issue_idx_r, cmp_idx_r, free_idx_r, slot_r;
  logic          issuing_r, cmp_vld_r, free_found_r;
  entry_t        ent_r;
  logic [GAP_BITS-1:0] gap_r;
  logic          late_r;
  logic [63:0]   sq_r;

  // output register
  logic          out_vld_r;
  logic [367:0]  out_data_r;
  logic [2:0]    out_user_r;

  // memory ports
  logic          mem_we;
  logic [IW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;

  // input field views
  logic [31:0] in_type, in_sender;
  logic [63:0] in_time;
  logic [3:0]  in_rslot;
  logic        in_acc;

  assign in_type   = in_tdata[31:0];
  assign in_sender = in_tdata[63:32];
  assign in_time   = in_tdata[127:64];
  assign in_rslot  = in_tdata[131:128];
  assign in_acc    = in_tvalid && in_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // APB port
  logic cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[3] == REG_MIN_GAP) ? {24'd0, min_start_r} : {63'd0, grp_r};

  psis_entry_mem #(.DEPTH(TABLE_ENTRIES), .IW(IW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  function automatic logic [367:0] pack_result(input logic [IW-1:0] s, input entry_t e,
                                               input logic [31:0] gl);
    pack_result = {4'd0, gl, e.late, e.sq, e.sum, e.max_gap, e.min_gap, e.count,
                   e.sender, e.etype, 4'(s)};
  endfunction

  // search compare and new entry
  logic   key_hit, cmp_last;
  entry_t new_ent;
  assign key_hit  = cmp_vld_r && valid_r[cmp_idx_r] && (mem_rdata.etype == type_r) &&
                    (mem_rdata.sender == sender_r);
  assign cmp_last = cmp_vld_r && (cmp_idx_r == LAST_IDX);

  always_comb begin
    new_ent         = '0;
    new_ent.etype   = type_r;
    new_ent.sender  = sender_r;
    new_ent.last    = time_r;
    new_ent.count   = 32'd1;
    new_ent.min_gap = min_start_r[GAP_BITS-1:0];
  end

  // gap subtractor and accumulators
  logic        t_late;
  logic [63:0] diff;
  logic [GAP_BITS-1:0] gap_sat;
  logic [56:0] sum_w;
  logic [64:0] sq_w;
  entry_t      upd_ent;

  assign t_late  = $signed(time_r) < $signed(ent_r.last);
  assign diff    = t_late ? ent_r.last - time_r : time_r - ent_r.last;
  assign gap_sat = (diff > 64'(GAP_MAX)) ? GAP_MAX : diff[GAP_BITS-1:0];
  assign sum_w   = {1'b0, ent_r.sum} + 57'(gap_r);
  assign sq_w    = {1'b0, ent_r.sq} + {1'b0, sq_r};

  always_comb begin
    upd_ent    = ent_r;
    upd_ent.sq = sq_w[64] ? '1 : sq_w[63:0];
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = free_idx_r;
    mem_wdata = new_ent;
    mem_raddr = issue_idx_r;
    case (state_r)
      S_IDLE:   mem_raddr = IW'(in_rslot);
      S_SEARCH: mem_we = key_hit ? 1'b0 : (cmp_last && free_found_r);
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = slot_r;
        mem_wdata = upd_ent;
      end
      default: mem_we = 1'b0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      grp_r        <= 1'b1;
      min_start_r  <= MIN_GAP_RESET;
      gseen_r      <= 1'b0;
      glast_r      <= '0;
      glate_r      <= '0;
      valid_r      <= '0;
      out_vld_r    <= 1'b0;
      issuing_r    <= 1'b0;
      cmp_vld_r    <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (cfg_paddr[3] == REG_GROUP) grp_r <= cfg_pwdata[0];
        else                           min_start_r <= cfg_pwdata[39:0];
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            type_r     <= in_type;
            sender_r   <= grp_r ? in_sender : 32'd0;
            time_r     <= in_time;
            case (cmd_t'(in_tuser))
              CMD_RECORD: begin
                if (gseen_r && ($signed(in_time) < $signed(glast_r)))
                  glate_r <= inc_sat32(glate_r);
                gseen_r      <= 1'b1;
                glast_r      <= in_time;
                issue_idx_r  <= '0;
                issuing_r    <= 1'b1;
                cmp_vld_r    <= 1'b0;
                free_found_r <= 1'b0;
                state_r      <= S_SEARCH;
              end
              CMD_READ: begin
                slot_r <= IW'(in_rslot);
                if ((32'(in_rslot) < TABLE_ENTRIES) && valid_r[IW'(in_rslot)]) begin
                  state_r <= S_RDWAIT;
                end else begin
                  out_user_r <= ST_READ_EMPTY;
                  out_data_r <= {364'd0, in_rslot} | pack_result('0, '0, glate_r);
                  out_vld_r  <= 1'b1;
                  state_r    <= S_OUT;
                end
              end
              CMD_CLEAR: begin
                valid_r    <= '0;
                out_user_r <= ST_CLEARED;
                out_data_r <= pack_result('0, '0, glate_r);
                out_vld_r  <= 1'b1;
                state_r    <= S_OUT;
              end
              default: begin
                out_user_r <= ST_READ_EMPTY;
                out_data_r <= pack_result('0, '0, glate_r);
                out_vld_r  <= 1'b1;
                state_r    <= S_OUT;
              end
            endcase
          end
        end
        S_SEARCH: begin
          cmp_idx_r <= issue_idx_r;
          if (key_hit) begin
            ent_r     <= mem_rdata;
            slot_r    <= cmp_idx_r;
            issuing_r <= 1'b0;
            cmp_vld_r <= 1'b0;
            state_r   <= S_GAP;
          end else begin
            // issue one slot read per cycle, compare the previous one
            if (issuing_r) begin
              if (!free_found_r && !valid_r[issue_idx_r]) begin
                free_found_r <= 1'b1;
                free_idx_r   <= issue_idx_r;
              end
              if (issue_idx_r == LAST_IDX) issuing_r <= 1'b0;
              else                          issue_idx_r <= issue_idx_r + 1'b1;
            end
            if (cmp_last) begin
              cmp_vld_r <= 1'b0;
              out_vld_r <= 1'b1;
              state_r   <= S_OUT;
              if (free_found_r) begin
                valid_r[free_idx_r] <= 1'b1;
                out_user_r <= ST_NEW;
                out_data_r <= pack_result(free_idx_r, new_ent, glate_r);
              end else begin
                out_user_r <= ST_FULL;
                out_data_r <= {300'd0, sender_r, type_r, 4'd0} | pack_result('0, '0, glate_r);
              end
            end else begin
              cmp_vld_r <= issuing_r;
            end
          end
        end
        S_RDWAIT: begin
          out_user_r <= ST_READ_VALID;
          out_data_r <= pack_result(slot_r, mem_rdata, glate_r);
          out_vld_r  <= 1'b1;
          state_r    <= S_OUT;
        end
        S_GAP: begin
          gap_r   <= gap_sat;
          late_r  <= t_late;
          state_r <= S_SQ;
        end
        S_SQ: begin
          sq_r <= (gap_r > GAP_BITS'(32'hFFFF_FFFF)) ? '1 :
                  64'(gap_r[31:0]) * 64'(gap_r[31:0]);
          ent_r.count <= inc_sat32(ent_r.count);
          if (gap_r < ent_r.min_gap) ent_r.min_gap <= gap_r;
          if (gap_r > ent_r.max_gap) ent_r.max_gap <= gap_r;
          ent_r.sum  <= sum_w[56] ? '1 : sum_w[55:0];
          if (late_r) ent_r.late <= inc_sat32(ent_r.late);
          ent_r.last <= time_r;
          state_r    <= S_WRITE;
        end
        S_WRITE: begin
          out_user_r <= ST_EXISTING;
          out_data_r <= pack_result(slot_r, upd_ent, glate_r);
          out_vld_r  <= 1'b1;
          state_r    <= S_OUT;
        end
        S_OUT: begin
          if (out_tready) begin
            out_vld_r <= 1'b0;
            state_r   <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // checks
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result is pending");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == CMD_CLEAR) |=> (valid_r == '0))
    else $error("clear left a slot valid");

  a_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> valid_r[$past(mem_waddr)])
    else $error("entry written to a free slot");

  a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH && key_hit) |=> (state_r == S_GAP))
    else $error("key hit did not start the update");

endmodule
`default_nettype wire

// ===== src/psis_entry_mem.sv =====
// Entry memory of the statistics table: one write port, one registered read port.
// Depends on psis_pkg for the entry type.
`default_nettype none
module psis_entry_mem #(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [IW-1:0]   waddr,
  input  wire psis_pkg::entry_t wdata,
  input  wire logic [IW-1:0]   raddr,
  output psis_pkg::entry_t     rdata
);
  import psis_pkg::*;

  entry_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
